// ===== src/tpc_pkg.sv =====
// Shared types and widths for the triangle plane clipper.
// Used by every module of the block; depends on nothing.
`default_nettype none
package tpc_pkg;
  localparam int CoordW   = 32;
  localparam int DiffW    = CoordW + 1;
  localparam int ProdW    = CoordW + DiffW;
  localparam int DistW    = ProdW + 2;
  localparam int DenW     = DistW + 1;
  localparam int MagW     = DistW - 1;
  localparam int NumW     = CoordW + MagW;
  localparam int QuotW    = CoordW;
  localparam int DivSteps = QuotW;
  localparam int ColorW   = 24;
  localparam int IdxW     = 3;

  typedef logic [2:0][CoordW-1:0] vec_t;
  typedef logic [DistW-1:0]       dist_t;
  typedef logic [DenW-1:0]        den_t;
  typedef logic [NumW-1:0]        num_t;

  typedef enum logic [IdxW-1:0] {
    REG_PX = 3'd0,
    REG_PY = 3'd1,
    REG_PZ = 3'd2,
    REG_NX = 3'd3,
    REG_NY = 3'd4,
    REG_NZ = 3'd5
  } reg_e;

  typedef enum logic [1:0] {
    CLIP_NONE,
    CLIP_ONE,
    CLIP_TWO,
    CLIP_ALL
  } clip_e;

  typedef struct packed {
    clip_e             kind;
    vec_t              ta;
    vec_t              tb;
    vec_t              tc;
    vec_t [1:0]        a;
    logic [1:0][2:0]   neg;
    logic [ColorW-1:0] color;
  } tri_t;
endpackage
`default_nettype wire

// ===== src/triangle_plane_clipper.sv =====
// Top level of the triangle plane clipper: configuration registers,
// pipeline, divider lanes and result sequencer. Depends on tpc_pkg,
// tpc_dist, tpc_isect and tpc_div.
//
// A triangle word is taken at a clock edge where start_i is high and busy_o
// is low. Plane point and normal are written over the cfg channel, which is
// always ready; indexes beyond the six registers are dropped.
// Results appear for one cycle with out_valid_o high; last_tri_o marks the
// final result of a triangle. A triangle fully outside gives no result.
// From acceptance to the cycle that carries the first result, a triangle
// passes three distance stages, four setup stages, 32 divider stages (one
// quotient bit each) and the output stage.
// A new triangle can enter every cycle while busy_o is low. A triangle
// split into two results holds the whole pipeline while its first result
// is shown, with busy_o high; the second result follows in the next cycle.
// Reset clears all valid bits and loads the default plane (the z = 0 plane,
// normal pointing to positive z). The receiver cannot stall the block.
`default_nettype none
module triangle_plane_clipper #(
  parameter int FRAC_BITS = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  output logic                              busy_o,
  input  logic signed [tpc_pkg::CoordW-1:0] v0_x_i,
  input  logic signed [tpc_pkg::CoordW-1:0] v0_y_i,
  input  logic signed [tpc_pkg::CoordW-1:0] v0_z_i,
  input  logic signed [tpc_pkg::CoordW-1:0] v1_x_i,
  input  logic signed [tpc_pkg::CoordW-1:0] v1_y_i,
  input  logic signed [tpc_pkg::CoordW-1:0] v1_z_i,
  input  logic signed [tpc_pkg::CoordW-1:0] v2_x_i,
  input  logic signed [tpc_pkg::CoordW-1:0] v2_y_i,
  input  logic signed [tpc_pkg::CoordW-1:0] v2_z_i,
  input  logic [tpc_pkg::ColorW-1:0]        tri_color_i,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [tpc_pkg::IdxW-1:0]          cfg_index_i,
  input  logic [tpc_pkg::CoordW-1:0]        cfg_data_i,
  output logic                              out_valid_o,
  output logic signed [tpc_pkg::CoordW-1:0] out0_x_o,
  output logic signed [tpc_pkg::CoordW-1:0] out0_y_o,
  output logic signed [tpc_pkg::CoordW-1:0] out0_z_o,
  output logic signed [tpc_pkg::CoordW-1:0] out1_x_o,
  output logic signed [tpc_pkg::CoordW-1:0] out1_y_o,
  output logic signed [tpc_pkg::CoordW-1:0] out1_z_o,
  output logic signed [tpc_pkg::CoordW-1:0] out2_x_o,
  output logic signed [tpc_pkg::CoordW-1:0] out2_y_o,
  output logic signed [tpc_pkg::CoordW-1:0] out2_z_o,
  output logic [tpc_pkg::ColorW-1:0]        out_color_o,
  output logic                              last_tri_o
);
  import tpc_pkg::*;

  localparam logic [CoordW-1:0] NzReset = CoordW'(64'd1 << FRAC_BITS);

  vec_t              pnt_q, nrm_q;
  logic              en, stall, accept;
  vec_t [2:0]        vtx_in;

  logic              d_vld;
  vec_t [2:0]        d_vtx;
  logic [ColorW-1:0] d_col;
  dist_t [2:0]       d_dist;

  logic              s_vld;
  tri_t              s_tri;
  num_t [1:0][2:0]   s_num;
  den_t [1:0]        s_den;

  logic [1:0][2:0][QuotW-1:0] quo;
  logic              vld_q [DivSteps];
  tri_t              pl_q  [DivSteps];

  logic              f_vld_q, phase_q;
  tri_t              f_tri_q;
  vec_t [1:0]        x_d, f_x_q;
  vec_t              o0, o1, o2;

  assign vtx_in = {{v2_z_i, v2_y_i, v2_x_i},
                   {v1_z_i, v1_y_i, v1_x_i},
                   {v0_z_i, v0_y_i, v0_x_i}};

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pnt_q <= '0;
      nrm_q <= {NzReset, CoordW'(0), CoordW'(0)};
    end else if (cfg_valid_i) begin
      unique case (reg_e'(cfg_index_i))
        REG_PX:  pnt_q[0] <= cfg_data_i;
        REG_PY:  pnt_q[1] <= cfg_data_i;
        REG_PZ:  pnt_q[2] <= cfg_data_i;
        REG_NX:  nrm_q[0] <= cfg_data_i;
        REG_NY:  nrm_q[1] <= cfg_data_i;
        REG_NZ:  nrm_q[2] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign stall  = f_vld_q && (f_tri_q.kind == CLIP_TWO) && !phase_q;
  assign en     = !stall;
  assign busy_o = stall;
  assign accept = start_i && !busy_o;

  tpc_dist u_dist (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (accept),
    .vtx_i   (vtx_in),
    .color_i (tri_color_i),
    .pnt_i   (pnt_q),
    .nrm_i   (nrm_q),
    .valid_o (d_vld),
    .vtx_o   (d_vtx),
    .color_o (d_col),
    .dist_o  (d_dist)
  );

  tpc_isect u_isect (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (d_vld),
    .vtx_i   (d_vtx),
    .color_i (d_col),
    .dist_i  (d_dist),
    .valid_o (s_vld),
    .tri_o   (s_tri),
    .num_o   (s_num),
    .den_o   (s_den)
  );

  for (genvar j = 0; j < 2; j++) begin : g_edge
    for (genvar k = 0; k < 3; k++) begin : g_axis
      tpc_div u_div (
        .clk_i (clk_i),
        .en_i  (en),
        .num_i (s_num[j][k]),
        .den_i (s_den[j]),
        .quo_o (quo[j][k])
      );
    end
  end

  for (genvar s = 0; s < DivSteps; s++) begin : g_delay
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[s] <= 1'b0;
      end else if (en) begin
        vld_q[s] <= (s == 0) ? s_vld : vld_q[(s == 0) ? 0 : s-1];
      end
    end
    always_ff @(posedge clk_i) begin
      if (en) begin
        pl_q[s] <= (s == 0) ? s_tri : pl_q[(s == 0) ? 0 : s-1];
      end
    end
  end

  always_comb begin
    for (int j = 0; j < 2; j++) begin
      for (int k = 0; k < 3; k++) begin
        x_d[j][k] = pl_q[DivSteps-1].neg[j][k]
                  ? pl_q[DivSteps-1].a[j][k] - quo[j][k]
                  : pl_q[DivSteps-1].a[j][k] + quo[j][k];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f_vld_q <= 1'b0;
      phase_q <= 1'b0;
    end else begin
      phase_q <= stall;
      if (en) begin
        f_vld_q <= vld_q[DivSteps-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      f_tri_q <= pl_q[DivSteps-1];
      f_x_q   <= x_d;
    end
  end

  always_comb begin
    o0 = f_tri_q.ta;
    o1 = f_tri_q.tb;
    o2 = f_tri_q.tc;
    last_tri_o = 1'b1;
    unique case (f_tri_q.kind)
      CLIP_ALL: begin
        o0 = f_tri_q.ta; o1 = f_tri_q.tb; o2 = f_tri_q.tc;
      end
      CLIP_ONE: begin
        o0 = f_tri_q.ta; o1 = f_x_q[0]; o2 = f_x_q[1];
      end
      CLIP_TWO: begin
        if (phase_q) begin
          o0 = f_tri_q.tb; o1 = f_x_q[0]; o2 = f_x_q[1];
        end else begin
          o0 = f_tri_q.ta; o1 = f_tri_q.tb; o2 = f_x_q[0];
          last_tri_o = 1'b0;
        end
      end
      CLIP_NONE: last_tri_o = 1'b1;
      default:   last_tri_o = 1'b1;
    endcase
  end

  assign out_valid_o = f_vld_q && (f_tri_q.kind != CLIP_NONE);
  assign out0_x_o    = o0[0];
  assign out0_y_o    = o0[1];
  assign out0_z_o    = o0[2];
  assign out1_x_o    = o1[0];
  assign out1_y_o    = o1[1];
  assign out1_z_o    = o1[2];
  assign out2_x_o    = o2[0];
  assign out2_y_o    = o2[1];
  assign out2_z_o    = o2[2];
  assign out_color_o = f_tri_q.color;

  a_first_then_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !last_tri_o |=> out_valid_o && last_tri_o)
    else $error("split triangle did not deliver its second word");

  a_first_holds_pipe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !last_tri_o |-> busy_o)
    else $error("first word of a split triangle without a pipeline hold");

  a_shared_vertex: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !last_tri_o |=> out0_x_o == $past(out1_x_o)
                                   && out1_z_o == $past(out2_z_o))
    else $error("second word of a split triangle lost its shared vertices");
endmodule
`default_nettype wire

// ===== src/tpc_dist.sv =====
// Signed plane distance of the three vertices, three register stages.
// Depends on tpc_pkg.
`default_nettype none
module tpc_dist (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       en_i,
  input  logic                       valid_i,
  input  tpc_pkg::vec_t [2:0]        vtx_i,
  input  logic [tpc_pkg::ColorW-1:0] color_i,
  input  tpc_pkg::vec_t              pnt_i,
  input  tpc_pkg::vec_t              nrm_i,
  output logic                       valid_o,
  output tpc_pkg::vec_t [2:0]        vtx_o,
  output logic [tpc_pkg::ColorW-1:0] color_o,
  output tpc_pkg::dist_t [2:0]       dist_o
);
  import tpc_pkg::*;

  logic                        vld1_q, vld2_q, vld3_q;
  vec_t [2:0]                  vtx1_q, vtx2_q, vtx3_q;
  logic [ColorW-1:0]           col1_q, col2_q, col3_q;
  logic [2:0][2:0][DiffW-1:0]  diff_d, diff1_q;
  logic [2:0][2:0][ProdW-1:0]  prod_d, prod2_q;
  dist_t [2:0]                 dist_d, dist3_q;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      for (int k = 0; k < 3; k++) begin
        diff_d[i][k] = {vtx_i[i][k][CoordW-1], vtx_i[i][k]}
                     - {pnt_i[k][CoordW-1], pnt_i[k]};
        prod_d[i][k] = $signed({{DiffW{nrm_i[k][CoordW-1]}}, nrm_i[k]})
                     * $signed({{CoordW{diff1_q[i][k][DiffW-1]}}, diff1_q[i][k]});
      end
      dist_d[i] = {{2{prod2_q[i][0][ProdW-1]}}, prod2_q[i][0]}
                + {{2{prod2_q[i][1][ProdW-1]}}, prod2_q[i][1]}
                + {{2{prod2_q[i][2][ProdW-1]}}, prod2_q[i][2]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld1_q <= 1'b0;
      vld2_q <= 1'b0;
      vld3_q <= 1'b0;
    end else if (en_i) begin
      vld1_q <= valid_i;
      vld2_q <= vld1_q;
      vld3_q <= vld2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      vtx1_q  <= vtx_i;
      col1_q  <= color_i;
      diff1_q <= diff_d;
      vtx2_q  <= vtx1_q;
      col2_q  <= col1_q;
      prod2_q <= prod_d;
      vtx3_q  <= vtx2_q;
      col3_q  <= col2_q;
      dist3_q <= dist_d;
    end
  end

  assign valid_o = vld3_q;
  assign vtx_o   = vtx3_q;
  assign color_o = col3_q;
  assign dist_o  = dist3_q;
endmodule
`default_nettype wire

// ===== src/tpc_isect.sv =====
// Inside test, edge selection and numerator products, four register stages.
// Depends on tpc_pkg.
`default_nettype none
module tpc_isect (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       en_i,
  input  logic                       valid_i,
  input  tpc_pkg::vec_t [2:0]        vtx_i,
  input  logic [tpc_pkg::ColorW-1:0] color_i,
  input  tpc_pkg::dist_t [2:0]       dist_i,
  output logic                       valid_o,
  output tpc_pkg::tri_t              tri_o,
  output tpc_pkg::num_t [1:0][2:0]   num_o,
  output tpc_pkg::den_t [1:0]        den_o
);
  import tpc_pkg::*;

  logic [2:0]        mask;
  clip_e             kind_d;
  logic [1:0]        ia0, ib0, ia1, ib1, ita, itb;

  logic              vld4_q, vld5_q, vld6_q, vld7_q;
  clip_e             kind4_q;
  vec_t              ta4_q, tb4_q, tc4_q;
  vec_t [1:0]        a4_q, b4_q;
  dist_t [1:0]       da4_q, db4_q;
  logic [ColorW-1:0] col4_q;

  logic [1:0][2:0][DiffW-1:0]  dd;
  logic [1:0][2:0][CoordW-1:0] mag_d, mag5_q;
  den_t [1:0]                  den_d, den5_q, den6_q, den7_q;
  logic [1:0][MagW-1:0]        da5_q;
  tri_t                        tri5_q, tri6_q, tri7_q;
  logic [1:0][2:0][63:0]       plo_d, plo6_q;
  logic [1:0][2:0][65:0]       phi_d, phi6_q;
  num_t [1:0][2:0]             num_d, num7_q;

  always_comb begin
    mask = {~dist_i[2][DistW-1], ~dist_i[1][DistW-1], ~dist_i[0][DistW-1]};
    kind_d = CLIP_NONE;
    ia0 = 2'd0; ib0 = 2'd0; ia1 = 2'd0; ib1 = 2'd0; ita = 2'd0; itb = 2'd1;
    unique case (mask)
      3'b000: kind_d = CLIP_NONE;
      3'b111: kind_d = CLIP_ALL;
      3'b001: begin
        kind_d = CLIP_ONE; ia0 = 2'd0; ib0 = 2'd1; ia1 = 2'd0; ib1 = 2'd2; ita = 2'd0;
      end
      3'b010: begin
        kind_d = CLIP_ONE; ia0 = 2'd1; ib0 = 2'd0; ia1 = 2'd1; ib1 = 2'd2; ita = 2'd1;
      end
      3'b100: begin
        kind_d = CLIP_ONE; ia0 = 2'd2; ib0 = 2'd0; ia1 = 2'd2; ib1 = 2'd1; ita = 2'd2;
      end
      3'b011: begin
        kind_d = CLIP_TWO; ia0 = 2'd0; ib0 = 2'd2; ia1 = 2'd1; ib1 = 2'd2;
        ita = 2'd0; itb = 2'd1;
      end
      3'b101: begin
        kind_d = CLIP_TWO; ia0 = 2'd0; ib0 = 2'd1; ia1 = 2'd2; ib1 = 2'd1;
        ita = 2'd0; itb = 2'd2;
      end
      3'b110: begin
        kind_d = CLIP_TWO; ia0 = 2'd1; ib0 = 2'd0; ia1 = 2'd2; ib1 = 2'd0;
        ita = 2'd1; itb = 2'd2;
      end
      default: kind_d = CLIP_NONE;
    endcase
  end

  always_comb begin
    for (int j = 0; j < 2; j++) begin
      den_d[j] = {da4_q[j][DistW-1], da4_q[j]} - {db4_q[j][DistW-1], db4_q[j]};
      for (int k = 0; k < 3; k++) begin
        dd[j][k] = {b4_q[j][k][CoordW-1], b4_q[j][k]} - {a4_q[j][k][CoordW-1], a4_q[j][k]};
        mag_d[j][k] = dd[j][k][DiffW-1] ? CoordW'(-dd[j][k]) : dd[j][k][CoordW-1:0];
        plo_d[j][k] = {32'd0, mag5_q[j][k]} * {32'd0, da5_q[j][31:0]};
        phi_d[j][k] = {34'd0, mag5_q[j][k]} * {32'd0, da5_q[j][MagW-1:32]};
        num_d[j][k] = {phi6_q[j][k], 32'd0} + {34'd0, plo6_q[j][k]};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld4_q <= 1'b0;
      vld5_q <= 1'b0;
      vld6_q <= 1'b0;
      vld7_q <= 1'b0;
    end else if (en_i) begin
      vld4_q <= valid_i;
      vld5_q <= vld4_q;
      vld6_q <= vld5_q;
      vld7_q <= vld6_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      kind4_q  <= kind_d;
      ta4_q    <= vtx_i[ita];
      tb4_q    <= vtx_i[itb];
      tc4_q    <= vtx_i[2];
      a4_q[0]  <= vtx_i[ia0];
      b4_q[0]  <= vtx_i[ib0];
      a4_q[1]  <= vtx_i[ia1];
      b4_q[1]  <= vtx_i[ib1];
      da4_q[0] <= dist_i[ia0];
      db4_q[0] <= dist_i[ib0];
      da4_q[1] <= dist_i[ia1];
      db4_q[1] <= dist_i[ib1];
      col4_q   <= color_i;

      tri5_q.kind  <= kind4_q;
      tri5_q.ta    <= ta4_q;
      tri5_q.tb    <= tb4_q;
      tri5_q.tc    <= tc4_q;
      tri5_q.a     <= a4_q;
      tri5_q.color <= col4_q;
      for (int j = 0; j < 2; j++) begin
        for (int k = 0; k < 3; k++) begin
          tri5_q.neg[j][k] <= dd[j][k][DiffW-1];
        end
        da5_q[j] <= da4_q[j][MagW-1:0];
      end
      mag5_q <= mag_d;
      den5_q <= den_d;

      tri6_q <= tri5_q;
      den6_q <= den5_q;
      plo6_q <= plo_d;
      phi6_q <= phi_d;

      tri7_q <= tri6_q;
      den7_q <= den6_q;
      num7_q <= num_d;
    end
  end

  assign valid_o = vld7_q;
  assign tri_o   = tri7_q;
  assign num_o   = num7_q;
  assign den_o   = den7_q;
endmodule
`default_nettype wire

// ===== src/tpc_div.sv =====
// Pipelined restoring divider, one quotient bit per register stage.
// Depends on tpc_pkg; the quotient is known to fit in QuotW bits.
`default_nettype none
module tpc_div (
  input  logic                      clk_i,
  input  logic                      en_i,
  input  tpc_pkg::num_t             num_i,
  input  tpc_pkg::den_t             den_i,
  output logic [tpc_pkg::QuotW-1:0] quo_o
);
  import tpc_pkg::*;

  den_t              rem_q [DivSteps];
  den_t              den_q [DivSteps];
  logic [QuotW-1:0]  low_q [DivSteps];
  logic [QuotW-1:0]  quo_q [DivSteps];

  for (genvar s = 0; s < DivSteps; s++) begin : g_step
    den_t             rem_in, den_in, rem_out;
    logic [QuotW-1:0] low_in, quo_in;
    logic [DenW:0]    trial, diff;

    if (s == 0) begin : g_first
      assign rem_in = DenW'(num_i[NumW-1:QuotW]);
      assign den_in = den_i;
      assign low_in = num_i[QuotW-1:0];
      assign quo_in = '0;
    end else begin : g_next
      assign rem_in = rem_q[s-1];
      assign den_in = den_q[s-1];
      assign low_in = low_q[s-1];
      assign quo_in = quo_q[s-1];
    end

    assign trial   = {rem_in, low_in[QuotW-1]};
    assign diff    = trial - {1'b0, den_in};
    assign rem_out = diff[DenW] ? trial[DenW-1:0] : diff[DenW-1:0];

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[s] <= rem_out;
        den_q[s] <= den_in;
        low_q[s] <= {low_in[QuotW-2:0], 1'b0};
        quo_q[s] <= {quo_in[QuotW-2:0], ~diff[DenW]};
      end
    end
  end

  assign quo_o = quo_q[DivSteps-1];
endmodule
`default_nettype wire
